// File: hdl/occ_pkg.sv
// Shared types, constants and the microprogram of the osculating circle block.
package occ_pkg;

    localparam int COORD_W   = 32;
    localparam int LABEL_W   = 16;
    localparam int TOL_W     = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int WIDE_W    = 6 * COORD_W + 16;
    localparam int NUM_VEC   = 12;
    localparam int NUM_REGS  = 25;
    localparam int RA_W      = 5;
    localparam int PC_W      = 7;
    localparam int PROG_LEN  = 79;
    localparam int TOL_RESET = 1;

    typedef logic [RA_W-1:0] t_ra;

    // register file map; the first NUM_VEC entries plus the tolerance are loaded per task
    localparam t_ra R_D1X = 5'd0;
    localparam t_ra R_D1Y = 5'd1;
    localparam t_ra R_D1Z = 5'd2;
    localparam t_ra R_D2X = 5'd3;
    localparam t_ra R_D2Y = 5'd4;
    localparam t_ra R_D2Z = 5'd5;
    localparam t_ra R_EX  = 5'd6;
    localparam t_ra R_EY  = 5'd7;
    localparam t_ra R_EZ  = 5'd8;
    localparam t_ra R_SX  = 5'd9;
    localparam t_ra R_SY  = 5'd10;
    localparam t_ra R_SZ  = 5'd11;
    localparam t_ra R_TOL = 5'd12;
    localparam t_ra R_DD1 = 5'd13;
    localparam t_ra R_DD2 = 5'd14;
    localparam t_ra R_EE  = 5'd15;
    localparam t_ra R_P12 = 5'd16;
    localparam t_ra R_S   = 5'd17;
    localparam t_ra R_CS  = 5'd18;
    localparam t_ra R_T   = 5'd19;
    localparam t_ra R_T2  = 5'd20;
    localparam t_ra R_CCX = 5'd21;
    localparam t_ra R_CCY = 5'd22;
    localparam t_ra R_CCZ = 5'd23;
    localparam t_ra R_C2  = 5'd24;

    // result field selectors for OP_OUT
    localparam t_ra F_CX  = 5'd0;
    localparam t_ra F_CY  = 5'd1;
    localparam t_ra F_CZ  = 5'd2;
    localparam t_ra F_RAD = 5'd3;

    typedef enum logic [3:0] {
        OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_SQRT, OP_CHKZ, OP_CHKGE, OP_OUT, OP_END
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_FETCH, S_SETUP, S_RUN, S_WB, S_EMIT
    } t_bstate;

    typedef struct packed {
        t_op op;
        t_ra dst;
        t_ra a;
        t_ra b;
    } t_uop;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      line_start;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic        [COORD_W-1:0] circle_radius;
        logic        [LABEL_W-1:0] line_label;
    } t_out_word;

    typedef struct packed {
        logic [NUM_VEC-1:0][DIFF_W-1:0] vec;
        logic [TOL_W-1:0]               tol;
        logic [LABEL_W-1:0]             label;
    } t_task;

    function automatic t_uop mk(input t_op op, input t_ra d, input t_ra a, input t_ra b);
        return t_uop'{op, d, a, b};
    endfunction

    function automatic t_uop prog(input logic [PC_W-1:0] pc);
        t_uop u;
        u = mk(OP_END, R_T, R_T, R_T);
        case (pc)
            7'd0:  u = mk(OP_MUL,   R_T,   R_D1X, R_D1X);
            7'd1:  u = mk(OP_MUL,   R_T2,  R_D1Y, R_D1Y);
            7'd2:  u = mk(OP_ADD,   R_DD1, R_T,   R_T2);
            7'd3:  u = mk(OP_MUL,   R_T,   R_D1Z, R_D1Z);
            7'd4:  u = mk(OP_ADD,   R_DD1, R_DD1, R_T);
            7'd5:  u = mk(OP_CHKZ,  R_T,   R_DD1, R_T);
            7'd6:  u = mk(OP_MUL,   R_T,   R_D2X, R_D2X);
            7'd7:  u = mk(OP_MUL,   R_T2,  R_D2Y, R_D2Y);
            7'd8:  u = mk(OP_ADD,   R_DD2, R_T,   R_T2);
            7'd9:  u = mk(OP_MUL,   R_T,   R_D2Z, R_D2Z);
            7'd10: u = mk(OP_ADD,   R_DD2, R_DD2, R_T);
            7'd11: u = mk(OP_MUL,   R_T,   R_EX,  R_EX);
            7'd12: u = mk(OP_MUL,   R_T2,  R_EY,  R_EY);
            7'd13: u = mk(OP_ADD,   R_EE,  R_T,   R_T2);
            7'd14: u = mk(OP_MUL,   R_T,   R_EZ,  R_EZ);
            7'd15: u = mk(OP_ADD,   R_EE,  R_EE,  R_T);
            7'd16: u = mk(OP_MUL,   R_T,   R_D1X, R_D2X);
            7'd17: u = mk(OP_MUL,   R_T2,  R_D1Y, R_D2Y);
            7'd18: u = mk(OP_ADD,   R_P12, R_T,   R_T2);
            7'd19: u = mk(OP_MUL,   R_T,   R_D1Z, R_D2Z);
            7'd20: u = mk(OP_ADD,   R_P12, R_P12, R_T);
            7'd21: u = mk(OP_MUL,   R_T,   R_D2X, R_EX);
            7'd22: u = mk(OP_MUL,   R_T2,  R_D2Y, R_EY);
            7'd23: u = mk(OP_ADD,   R_S,   R_T,   R_T2);
            7'd24: u = mk(OP_MUL,   R_T,   R_D2Z, R_EZ);
            7'd25: u = mk(OP_ADD,   R_S,   R_S,   R_T);
            7'd26: u = mk(OP_MUL,   R_T,   R_D1Y, R_D2Z);
            7'd27: u = mk(OP_MUL,   R_T2,  R_D1Z, R_D2Y);
            7'd28: u = mk(OP_SUB,   R_CCX, R_T,   R_T2);
            7'd29: u = mk(OP_MUL,   R_T,   R_D1Z, R_D2X);
            7'd30: u = mk(OP_MUL,   R_T2,  R_D1X, R_D2Z);
            7'd31: u = mk(OP_SUB,   R_CCY, R_T,   R_T2);
            7'd32: u = mk(OP_MUL,   R_T,   R_D1X, R_D2Y);
            7'd33: u = mk(OP_MUL,   R_T2,  R_D1Y, R_D2X);
            7'd34: u = mk(OP_SUB,   R_CCZ, R_T,   R_T2);
            7'd35: u = mk(OP_MUL,   R_CS,  R_CCX, R_CCX);
            7'd36: u = mk(OP_MUL,   R_T,   R_CCY, R_CCY);
            7'd37: u = mk(OP_ADD,   R_CS,  R_CS,  R_T);
            7'd38: u = mk(OP_MUL,   R_T,   R_CCZ, R_CCZ);
            7'd39: u = mk(OP_ADD,   R_CS,  R_CS,  R_T);
            7'd40: u = mk(OP_CHKZ,  R_T,   R_CS,  R_T);
            7'd41: u = mk(OP_MUL,   R_T,   R_TOL, R_TOL);
            7'd42: u = mk(OP_MUL,   R_T,   R_T,   R_DD1);
            7'd43: u = mk(OP_CHKGE, R_T,   R_CS,  R_T);
            7'd44: u = mk(OP_ADD,   R_C2,  R_CS,  R_CS);
            7'd45: u = mk(OP_MUL,   R_T,   R_DD1, R_D2X);
            7'd46: u = mk(OP_MUL,   R_T2,  R_P12, R_D1X);
            7'd47: u = mk(OP_SUB,   R_T,   R_T,   R_T2);
            7'd48: u = mk(OP_MUL,   R_T,   R_S,   R_T);
            7'd49: u = mk(OP_MUL,   R_T2,  R_SX,  R_CS);
            7'd50: u = mk(OP_ADD,   R_T,   R_T,   R_T2);
            7'd51: u = mk(OP_ADD,   R_T,   R_T,   R_CS);
            7'd52: u = mk(OP_DIV,   R_T,   R_T,   R_C2);
            7'd53: u = mk(OP_OUT,   F_CX,  R_T,   R_T);
            7'd54: u = mk(OP_MUL,   R_T,   R_DD1, R_D2Y);
            7'd55: u = mk(OP_MUL,   R_T2,  R_P12, R_D1Y);
            7'd56: u = mk(OP_SUB,   R_T,   R_T,   R_T2);
            7'd57: u = mk(OP_MUL,   R_T,   R_S,   R_T);
            7'd58: u = mk(OP_MUL,   R_T2,  R_SY,  R_CS);
            7'd59: u = mk(OP_ADD,   R_T,   R_T,   R_T2);
            7'd60: u = mk(OP_ADD,   R_T,   R_T,   R_CS);
            7'd61: u = mk(OP_DIV,   R_T,   R_T,   R_C2);
            7'd62: u = mk(OP_OUT,   F_CY,  R_T,   R_T);
            7'd63: u = mk(OP_MUL,   R_T,   R_DD1, R_D2Z);
            7'd64: u = mk(OP_MUL,   R_T2,  R_P12, R_D1Z);
            7'd65: u = mk(OP_SUB,   R_T,   R_T,   R_T2);
            7'd66: u = mk(OP_MUL,   R_T,   R_S,   R_T);
            7'd67: u = mk(OP_MUL,   R_T2,  R_SZ,  R_CS);
            7'd68: u = mk(OP_ADD,   R_T,   R_T,   R_T2);
            7'd69: u = mk(OP_ADD,   R_T,   R_T,   R_CS);
            7'd70: u = mk(OP_DIV,   R_T,   R_T,   R_C2);
            7'd71: u = mk(OP_OUT,   F_CZ,  R_T,   R_T);
            7'd72: u = mk(OP_MUL,   R_T,   R_DD1, R_DD2);
            7'd73: u = mk(OP_MUL,   R_T,   R_T,   R_EE);
            7'd74: u = mk(OP_ADD,   R_T2,  R_C2,  R_C2);
            7'd75: u = mk(OP_DIV,   R_T,   R_T,   R_T2);
            7'd76: u = mk(OP_SQRT,  R_T,   R_T,   R_T);
            7'd77: u = mk(OP_OUT,   F_RAD, R_T,   R_T);
            default: u = mk(OP_END, R_T,   R_T,   R_T);
        endcase
        return u;
    endfunction

endpackage

// File: hdl/occ_front.sv
// Front end: point history, line counting, tolerance register and task build.
module occ_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  occ_pkg::t_in_word          i_word,
    input  logic                       i_cfg_we,
    input  logic [occ_pkg::TOL_W-1:0]  i_cfg_wdata,
    input  logic                       i_full,
    output logic                       o_push,
    output occ_pkg::t_task             o_task
);

    localparam int W  = occ_pkg::COORD_W;
    localparam int DW = occ_pkg::DIFF_W;
    localparam logic [1:0] PTS_FULL = 2'd2;

    logic [occ_pkg::TOL_W-1:0]   r_tol;
    logic [occ_pkg::LABEL_W-1:0] r_label, n_label;
    logic [1:0]                  r_count, n_count, cnt_eff;
    logic [2:0][W-1:0]           r_old, r_new, cur;
    logic                        accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign cur[0]  = i_word.point_x;
    assign cur[1]  = i_word.point_y;
    assign cur[2]  = i_word.point_z;

    always_comb begin
        cnt_eff = i_word.line_start ? 2'd0 : r_count;
        n_label = i_word.line_start ? r_label + 1'b1 : r_label;
        n_count = (cnt_eff == PTS_FULL) ? PTS_FULL : cnt_eff + 2'd1;
        o_push  = accept && (cnt_eff == PTS_FULL);
    end

    always_comb begin
        o_task.tol   = r_tol;
        o_task.label = n_label;
        o_task.vec   = '0;
        for (int j = 0; j < 3; j++) begin
            o_task.vec[occ_pkg::R_D1X + j] = DW'({r_new[j][W-1], r_new[j]}
                                               - {r_old[j][W-1], r_old[j]});
            o_task.vec[occ_pkg::R_D2X + j] = DW'({cur[j][W-1], cur[j]}
                                               - {r_new[j][W-1], r_new[j]});
            o_task.vec[occ_pkg::R_EX + j]  = DW'({cur[j][W-1], cur[j]}
                                               - {r_old[j][W-1], r_old[j]});
            o_task.vec[occ_pkg::R_SX + j]  = DW'({r_old[j][W-1], r_old[j]}
                                               + {r_new[j][W-1], r_new[j]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= occ_pkg::TOL_W'(occ_pkg::TOL_RESET);
            r_label <= '1;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (accept) begin
                r_label <= n_label;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old <= r_new;
            r_new <= cur;
        end
    end

endmodule

// File: hdl/occ_queue.sv
// Task queue between front and back ends.
module occ_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  occ_pkg::t_task i_task,
    output logic           o_full,
    output logic           o_task_valid,
    output occ_pkg::t_task o_task,
    input  logic           i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    occ_pkg::t_task   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full       = (r_cnt == CNT_W'(DEPTH));
    assign o_task_valid = (r_cnt != '0);
    assign o_task       = r_mem[r_rp];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_task_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_task;
        end
    end

endmodule

// File: hdl/occ_back.sv
// Back end: microcoded bit-serial multiply, divide and square root over a register file.
module occ_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_task_valid,
    input  occ_pkg::t_task     i_task,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output occ_pkg::t_out_word o_word
);

    localparam int WW   = occ_pkg::WIDE_W;
    localparam int W    = occ_pkg::COORD_W;
    localparam int DW   = occ_pkg::DIFF_W;
    localparam int IT_W = $clog2(WW + 1);
    localparam int VI_W = $clog2(occ_pkg::NUM_VEC);

    occ_pkg::t_bstate r_state, n_state;
    occ_pkg::t_uop    uop;

    logic [occ_pkg::PC_W-1:0]    r_pc;
    logic [occ_pkg::RA_W-1:0]    r_cnt;
    logic [WW-1:0]               r_rf [occ_pkg::NUM_REGS];
    logic [WW-1:0]               r_rd_a, r_rd_b;
    logic                        rf_we;
    logic [occ_pkg::RA_W-1:0]    rf_wa;
    logic [WW-1:0]               rf_wd, load_val;

    logic [WW-1:0]               r_acc, r_x, r_y, r_rem, r_root, r_res;
    logic                        r_neg;
    logic [IT_W-1:0]             r_iter;
    logic [occ_pkg::LABEL_W-1:0] r_label;
    logic [W-1:0]                r_cx, r_cy, r_cz, r_rad;
    logic                        r_ovalid;
    occ_pkg::t_out_word          r_oword;

    logic                        run_done, pc_step, emit_go;
    logic [WW-1:0]               abs_a, abs_b;
    logic [WW:0]                 div_rs;
    logic                        div_ge;
    logic [WW+1:0]               sq_rs, sq_trial;
    logic                        sq_ge;
    logic [WW-W:0]               hi_bits;
    logic [W-1:0]                sat_s, sat_u;

    assign uop = occ_pkg::prog(r_pc);

    // datapath helpers
    always_comb begin
        abs_a    = r_rd_a[WW-1] ? (~r_rd_a + WW'(1)) : r_rd_a;
        abs_b    = r_rd_b[WW-1] ? (~r_rd_b + WW'(1)) : r_rd_b;
        div_rs   = {r_rem, r_x[WW-1]};
        div_ge   = (div_rs >= {1'b0, r_y});
        sq_rs    = {r_rem, r_x[WW-1:WW-2]};
        sq_trial = {r_root, 2'b01};
        sq_ge    = (sq_rs >= sq_trial);
        hi_bits  = r_rd_a[WW-1:W-1];
        if (&hi_bits || ~|hi_bits) begin
            sat_s = r_rd_a[W-1:0];
        end else if (r_rd_a[WW-1]) begin
            sat_s = {1'b1, {(W-1){1'b0}}};
        end else begin
            sat_s = {1'b0, {(W-1){1'b1}}};
        end
        sat_u = (|r_rd_a[WW-1:W]) ? '1 : r_rd_a[W-1:0];
        case (uop.op)
            occ_pkg::OP_MUL:  run_done = (r_y == '0);
            occ_pkg::OP_DIV,
            occ_pkg::OP_SQRT: run_done = (r_iter == '0);
            default:          run_done = 1'b1;
        endcase
        if (r_cnt < occ_pkg::RA_W'(occ_pkg::NUM_VEC)) begin
            load_val = {{(WW-DW){i_task.vec[r_cnt[VI_W-1:0]][DW-1]}},
                        i_task.vec[r_cnt[VI_W-1:0]]};
        end else begin
            load_val = {{(WW-occ_pkg::TOL_W){1'b0}}, i_task.tol};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            occ_pkg::S_IDLE:  if (i_task_valid) n_state = occ_pkg::S_LOAD;
            occ_pkg::S_LOAD:  if (r_cnt == occ_pkg::R_TOL) n_state = occ_pkg::S_FETCH;
            occ_pkg::S_FETCH: n_state = occ_pkg::S_SETUP;
            occ_pkg::S_SETUP: begin
                unique case (uop.op) inside
                    occ_pkg::OP_ADD, occ_pkg::OP_SUB:
                        n_state = occ_pkg::S_WB;
                    occ_pkg::OP_MUL, occ_pkg::OP_DIV, occ_pkg::OP_SQRT:
                        n_state = occ_pkg::S_RUN;
                    occ_pkg::OP_CHKZ:
                        n_state = (r_rd_a == '0) ? occ_pkg::S_IDLE : occ_pkg::S_FETCH;
                    occ_pkg::OP_CHKGE:
                        n_state = ($signed(r_rd_a) < $signed(r_rd_b)) ? occ_pkg::S_IDLE
                                                                      : occ_pkg::S_FETCH;
                    occ_pkg::OP_OUT:
                        n_state = occ_pkg::S_FETCH;
                    occ_pkg::OP_END:
                        n_state = occ_pkg::S_EMIT;
                    default:
                        n_state = occ_pkg::S_IDLE;
                endcase
            end
            occ_pkg::S_RUN:   if (run_done) n_state = occ_pkg::S_WB;
            occ_pkg::S_WB:    n_state = occ_pkg::S_FETCH;
            occ_pkg::S_EMIT:  if (!r_ovalid || i_ready) n_state = occ_pkg::S_IDLE;
            default:          n_state = occ_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop   = (r_state == occ_pkg::S_LOAD) && (r_cnt == occ_pkg::R_TOL);
        rf_we   = (r_state == occ_pkg::S_LOAD) || (r_state == occ_pkg::S_WB);
        rf_wa   = (r_state == occ_pkg::S_LOAD) ? r_cnt : uop.dst;
        rf_wd   = (r_state == occ_pkg::S_LOAD) ? load_val : r_res;
        pc_step = (r_state == occ_pkg::S_WB)
               || ((r_state == occ_pkg::S_SETUP) && (n_state == occ_pkg::S_FETCH));
        emit_go = (r_state == occ_pkg::S_EMIT) && (!r_ovalid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= occ_pkg::S_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == occ_pkg::S_IDLE) begin
                r_cnt <= '0;
            end else if (r_state == occ_pkg::S_LOAD) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (o_pop) begin
                r_pc <= '0;
            end else if (pc_step) begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end

    // register file, registered reads
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        r_rd_a <= r_rf[uop.a];
        r_rd_b <= r_rf[uop.b];
    end

    // shared arithmetic unit
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_label <= i_task.label;
        end
        unique case (r_state)
            occ_pkg::S_SETUP: begin
                case (uop.op)
                    occ_pkg::OP_ADD: r_res <= r_rd_a + r_rd_b;
                    occ_pkg::OP_SUB: r_res <= r_rd_a - r_rd_b;
                    occ_pkg::OP_MUL: begin
                        r_acc <= '0;
                        r_x   <= abs_a;
                        r_y   <= abs_b;
                        r_neg <= r_rd_a[WW-1] ^ r_rd_b[WW-1];
                    end
                    occ_pkg::OP_DIV: begin
                        // floor of a negative numerator: -((-a + b - 1) / b)
                        r_neg  <= r_rd_a[WW-1];
                        r_x    <= r_rd_a[WW-1] ? (~r_rd_a + r_rd_b) : r_rd_a;
                        r_y    <= r_rd_b;
                        r_rem  <= '0;
                        r_iter <= IT_W'(WW);
                    end
                    occ_pkg::OP_SQRT: begin
                        r_x    <= r_rd_a;
                        r_rem  <= '0;
                        r_root <= '0;
                        r_iter <= IT_W'(WW / 2);
                    end
                    occ_pkg::OP_OUT: begin
                        case (uop.dst)
                            occ_pkg::F_CX:  r_cx  <= sat_s;
                            occ_pkg::F_CY:  r_cy  <= sat_s;
                            occ_pkg::F_CZ:  r_cz  <= sat_s;
                            occ_pkg::F_RAD: r_rad <= sat_u;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            occ_pkg::S_RUN: begin
                case (uop.op)
                    occ_pkg::OP_MUL: begin
                        if (run_done) begin
                            r_res <= r_neg ? (~r_acc + WW'(1)) : r_acc;
                        end else begin
                            if (r_y[0]) begin
                                r_acc <= r_acc + r_x;
                            end
                            r_x <= {r_x[WW-2:0], 1'b0};
                            r_y <= {1'b0, r_y[WW-1:1]};
                        end
                    end
                    occ_pkg::OP_DIV: begin
                        if (run_done) begin
                            r_res <= r_neg ? (~r_x + WW'(1)) : r_x;
                        end else begin
                            r_rem  <= div_ge ? WW'(div_rs - {1'b0, r_y}) : div_rs[WW-1:0];
                            r_x    <= {r_x[WW-2:0], div_ge};
                            r_iter <= r_iter - 1'b1;
                        end
                    end
                    occ_pkg::OP_SQRT: begin
                        if (run_done) begin
                            r_res <= r_root;
                        end else begin
                            r_rem  <= sq_ge ? WW'(sq_rs - sq_trial) : sq_rs[WW-1:0];
                            r_root <= {r_root[WW-2:0], sq_ge};
                            r_x    <= {r_x[WW-3:0], 2'b00};
                            r_iter <= r_iter - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit_go) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_oword.center_x      <= r_cx;
            r_oword.center_y      <= r_cy;
            r_oword.center_z      <= r_cz;
            r_oword.circle_radius <= r_rad;
            r_oword.line_label    <= r_label;
        end
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_oword;

`ifndef NO_ASSERTIONS
    a_pop_has_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_task_valid)
        else $error("task popped from empty queue");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == occ_pkg::S_EMIT)
        else $error("result word appeared without emit");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == occ_pkg::S_RUN && uop.op == occ_pkg::OP_DIV) |-> r_y != '0)
        else $error("division by zero reached");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == occ_pkg::S_FETCH) |-> r_pc < occ_pkg::PC_W'(occ_pkg::PROG_LEN))
        else $error("microprogram counter out of range");
`endif

endmodule

// File: hdl/osculating_circle_center.sv
// Top level of the osculating circle center block.
//
// Input channel i_valid/o_ready/i_word carries one polyline point per word,
// signed Q16.16, with line_start marking the first point of a new line.
// Output channel o_valid/i_ready/o_word carries center, radius and label of
// the circle through the previous, current and next point of a line.
// i_cfg_we/i_cfg_wdata write the degenerate tolerance (reset value 1).
// The front end takes a word per cycle while the task queue has room and
// hands each interior point to the back end as one task.
// The back end runs a 79-step microprogram on one bit-serial unit: a multiply
// steps through the bits of its second operand, each of the four divisions
// iterates over every bit of the register width and the square root over
// every bit pair of it; rejected points finish after the failing check.
// Points without two earlier points in their line go no further than the front end.
// Reset clears the queue, the sequencer and the output register; the line
// label restarts so that the first flagged line is label 0.
// A stalled receiver holds the result in the output register; the back end
// waits at the end of its next task and the queue then fills up.
module osculating_circle_center #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  occ_pkg::t_in_word         i_word,
    output logic                      o_valid,
    input  logic                      i_ready,
    output occ_pkg::t_out_word        o_word,
    input  logic                      i_cfg_we,
    input  logic [occ_pkg::TOL_W-1:0] i_cfg_wdata
);

    logic           push, full, task_valid, pop;
    occ_pkg::t_task push_task, head_task;

    occ_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_word      (i_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (full),
        .o_push      (push),
        .o_task      (push_task)
    );

    occ_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_task       (push_task),
        .o_full       (full),
        .o_task_valid (task_valid),
        .o_task       (head_task),
        .i_pop        (pop)
    );

    occ_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (task_valid),
        .i_task       (head_task),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word       (o_word)
    );

endmodule

// File: tb/tb_osculating_circle_center.sv
// Testbench for osculating_circle_center: random polylines checked against an exact circle predictor.
`timescale 1ns / 100ps

module tb_osculating_circle_center;
    import occ_pkg::*;

    typedef logic signed [319:0] wide_t;

    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_CYCLES = 8000;
    localparam int LONG_HOLD = 30000;
    localparam longint CYCLE_LIMIT = 12000000;

    localparam int MODE_FULL = 0;
    localparam int MODE_SMALL = 1;
    localparam int MODE_MID = 2;

    class circle_scoreboard;
        logic [TOL_W-1:0] tol;
        wide_t older[3];
        wide_t newer[3];
        int unsigned held;
        logic [LABEL_W-1:0] label;
        t_out_word centers_due[$];
        int errors;

        function new();
            tol = TOL_W'(TOL_RESET);
            for (int j = 0; j < 3; j++) begin
                older[j] = 0;
                newer[j] = 0;
            end
            held = 0;
            label = '1;
            errors = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        function wide_t floor_div(wide_t n, wide_t d);
            wide_t q;
            q = n / d;
            if (n < 0 && q * d != n) q = q - 1;
            return q;
        endfunction

        function logic [COORD_W-1:0] sat_coord(wide_t v);
            wide_t hi;
            wide_t lo;
            hi = 2147483647;
            lo = -hi - 1;
            if (v > hi) return hi[COORD_W-1:0];
            if (v < lo) return lo[COORD_W-1:0];
            return v[COORD_W-1:0];
        endfunction

        function logic [COORD_W-1:0] sat_sqrt(wide_t r2);
            logic [63:0] top;
            logic [63:0] r;
            logic [63:0] cand;
            wide_t tw;
            wide_t cw;
            top = 64'hFFFF_FFFF;
            tw = top;
            if (tw * tw <= r2) return '1;
            r = 0;
            for (int b = COORD_W - 1; b >= 0; b--) begin
                cand = r | (64'd1 << b);
                cw = cand;
                if (cw * cw <= r2) r = cand;
            end
            return r[COORD_W-1:0];
        endfunction

        function void note_point(t_in_word w);
            wide_t cur[3];
            wide_t d1[3];
            wide_t d2[3];
            wide_t e[3];
            wide_t cc[3];
            wide_t dd1, dd2, ee, p12, s, csq, tw, wv, num;
            logic [COORD_W-1:0] ctr[3];
            t_out_word o;
            cur[0] = $signed(w.point_x);
            cur[1] = $signed(w.point_y);
            cur[2] = $signed(w.point_z);
            if (w.line_start) begin
                label++;
                held = 0;
            end
            if (held >= 2) begin
                for (int j = 0; j < 3; j++) begin
                    d1[j] = newer[j] - older[j];
                    d2[j] = cur[j] - newer[j];
                    e[j] = cur[j] - older[j];
                end
                dd1 = d1[0] * d1[0] + d1[1] * d1[1] + d1[2] * d1[2];
                dd2 = d2[0] * d2[0] + d2[1] * d2[1] + d2[2] * d2[2];
                ee = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
                p12 = d1[0] * d2[0] + d1[1] * d2[1] + d1[2] * d2[2];
                s = d2[0] * e[0] + d2[1] * e[1] + d2[2] * e[2];
                cc[0] = d1[1] * d2[2] - d1[2] * d2[1];
                cc[1] = d1[2] * d2[0] - d1[0] * d2[2];
                cc[2] = d1[0] * d2[1] - d1[1] * d2[0];
                csq = cc[0] * cc[0] + cc[1] * cc[1] + cc[2] * cc[2];
                tw = {304'd0, tol};
                if (dd1 != 0 && csq != 0 && csq >= tw * tw * dd1) begin
                    for (int j = 0; j < 3; j++) begin
                        wv = dd1 * d2[j] - p12 * d1[j];
                        num = (older[j] + newer[j]) * csq + s * wv;
                        ctr[j] = sat_coord(floor_div(num + csq, 2 * csq));
                    end
                    o.center_x = ctr[0];
                    o.center_y = ctr[1];
                    o.center_z = ctr[2];
                    o.circle_radius = sat_sqrt((dd1 * dd2 * ee) / (4 * csq));
                    o.line_label = label;
                    centers_due.push_back(o);
                end
            end
            for (int j = 0; j < 3; j++) begin
                older[j] = newer[j];
                newer[j] = cur[j];
            end
            if (held < 2) held++;
        endfunction

        function void check_center(t_out_word got);
            t_out_word want;
            if (centers_due.size() == 0) begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            want = centers_due.pop_front();
            if (got.center_x !== want.center_x)
                report($sformatf("center_x got %h want %h", got.center_x, want.center_x));
            if (got.center_y !== want.center_y)
                report($sformatf("center_y got %h want %h", got.center_y, want.center_y));
            if (got.center_z !== want.center_z)
                report($sformatf("center_z got %h want %h", got.center_z, want.center_z));
            if (got.circle_radius !== want.circle_radius)
                report($sformatf("radius got %h want %h",
                                 got.circle_radius, want.circle_radius));
            if (got.line_label !== want.line_label)
                report($sformatf("label got %h want %h", got.line_label, want.line_label));
        endfunction

        function int pending();
            return centers_due.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in_word i_word;
    logic o_valid;
    logic i_ready;
    t_out_word o_word;
    logic i_cfg_we;
    logic [TOL_W-1:0] i_cfg_wdata;

    circle_scoreboard sb;
    longint cycles;
    bit hold_req;
    int hold_left;
    int stall_mode;
    int gap_max;
    t_in_word prev1, prev2;

    osculating_circle_center dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_word(i_word),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_word(o_word),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_center(o_word);
    end

    // receiver: long hold on request, otherwise a stall pattern picked at random from four modes
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= LONG_HOLD;
            hold_req <= 1'b0;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= $urandom_range(0, 1);
                2: i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic send_word(t_in_word w);
        int gap;
        i_valid <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (!o_ready);
        sb.note_point(w);
        if (gap_max > 0 && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, gap_max);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_pt(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic ls);
        t_in_word w;
        w.point_x = x;
        w.point_y = y;
        w.point_z = z;
        w.line_start = ls;
        send_word(w);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tol(logic [TOL_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.tol = v;
    endtask

    function automatic logic [31:0] rnd_coord(int mode);
        case (mode)
            MODE_FULL: return $urandom;
            MODE_SMALL: return 32'($signed($urandom_range(0, 4095)) - 2048);
            default: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    task automatic send_lines(int count);
        int sent;
        int len;
        int mode;
        int pick;
        bit noise;
        t_in_word w;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 9);
            mode = $urandom_range(0, 2);
            noise = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 19);
                w.point_x = rnd_coord(mode);
                w.point_y = rnd_coord(mode);
                w.point_z = rnd_coord(mode);
                if (k > 0 && pick == 0) begin
                    w = prev1;
                end else if (k > 1 && pick == 1) begin
                    w.point_x = 2 * prev1.point_x - prev2.point_x;
                    w.point_y = 2 * prev1.point_y - prev2.point_y;
                    w.point_z = 2 * prev1.point_z - prev2.point_z;
                end
                w.line_start = noise ? 1'($urandom_range(0, 1)) : (k == 0);
                send_word(w);
                prev2 = prev1;
                prev1 = w;
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        hold_req = 1'b0;
        hold_left = 0;
        stall_mode = 0;
        gap_max = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_word = '0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        prev1 = '0;
        prev2 = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no line start yet: label stays all ones
        send_pt(32'h0, 32'h0, 32'h0, 1'b0);
        send_pt(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        send_pt(32'h0, 32'h0001_0000, 32'h0, 1'b0);
        // extremes of every coordinate
        send_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
        send_pt(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        // short lines: two lines of one point each
        send_pt(32'h1234_5678, 32'h0, 32'h0, 1'b1);
        send_pt(32'h0, 32'h0, 32'h0, 1'b1);
        send_pt(32'h0002_0000, 32'h0, 32'h0, 1'b1);
        // repeated point, then collinear
        send_pt(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0);
        send_pt(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0);
        send_pt(32'h0003_0000, 32'h0003_0000, 32'h0, 1'b0);
        send_pt(32'h0005_0000, 32'h0005_0000, 32'h0, 1'b0);
        send_pt(32'h0005_0000, 32'h0005_0003, 32'h0000_0001, 1'b0);
        go_idle();

        // tolerance boundary: offset 5 emits, offset 4 is rejected
        write_tol(16'd5);
        send_pt(32'h0, 32'h0, 32'h0, 1'b1);
        send_pt(32'h0000_0100, 32'h0, 32'h0, 1'b0);
        send_pt(32'h0000_0100, 32'h0000_0005, 32'h0, 1'b0);
        send_pt(32'h0, 32'h0, 32'h0, 1'b1);
        send_pt(32'h0000_0100, 32'h0, 32'h0, 1'b0);
        send_pt(32'h0000_0100, 32'h0000_0004, 32'h0, 1'b0);
        go_idle();

        write_tol(16'd0);
        gap_max = 0;
        send_lines(190);
        go_idle();

        write_tol(16'hFFFF);
        gap_max = 6;
        hold_req <= 1'b1;
        send_lines(190);
        go_idle();

        write_tol(16'd1);
        gap_max = 30;
        send_lines(190);
        go_idle();

        write_tol(16'($urandom_range(0, 255)));
        gap_max = 3;
        send_lines(190);
        go_idle();

        write_tol(16'($urandom));
        gap_max = 12;
        send_lines(170);
        go_idle();

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/occ_pkg.sv
hdl/occ_front.sv
hdl/occ_queue.sv
hdl/occ_back.sv
hdl/osculating_circle_center.sv
tb/tb_osculating_circle_center.sv
